// ===== rtl/core/lidtf_pkg.sv =====
`default_nettype none

package lidtf_pkg;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        scan_start;
    } t_in_item;

    typedef struct packed {
        logic [15:0] range_out;
        logic        keep;
    } t_out_item;

    typedef struct packed {
        logic [15:0] range_mm;
        logic [31:0] angle;
    } t_job;

    typedef struct packed {
        logic        [15:0] min_range;
        logic signed [15:0] tilt_sine;
        logic signed [15:0] height_floor;
    } t_back_cfg;

    localparam logic [2:0] REG_ANGLE_STEP   = 3'd0;
    localparam logic [2:0] REG_START_ANGLE  = 3'd1;
    localparam logic [2:0] REG_MIN_RANGE    = 3'd2;
    localparam logic [2:0] REG_TILT_SINE    = 3'd3;
    localparam logic [2:0] REG_HEIGHT_FLOOR = 3'd4;

    localparam logic [15:0] ANGLE_STEP_RST   = 16'd46;
    localparam logic [15:0] START_ANGLE_RST  = 16'hE000;
    localparam logic [15:0] MIN_RANGE_RST    = 16'd0;
    localparam logic [15:0] TILT_SINE_RST    = 16'd0;
    localparam logic [15:0] HEIGHT_FLOOR_RST = 16'hFF6A;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] CORDIC_LAST = 4'd15;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    function automatic logic [31:0] atan_turn(input logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0: v = 32'd536870912;
            4'd1: v = 32'd316933406;
            4'd2: v = 32'd167458907;
            4'd3: v = 32'd85004756;
            4'd4: v = 32'd42667331;
            4'd5: v = 32'd21354465;
            4'd6: v = 32'd10680862;
            4'd7: v = 32'd5340245;
            4'd8: v = 32'd2670163;
            4'd9: v = 32'd1335087;
            4'd10: v = 32'd667544;
            4'd11: v = 32'd333772;
            4'd12: v = 32'd166886;
            4'd13: v = 32'd83443;
            4'd14: v = 32'd41722;
            4'd15: v = 32'd20861;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lidtf_front.sv =====
`default_nettype none

module lidtf_front #(
    parameter int ANGLE_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  lidtf_pkg::t_in_item  i_item,
    input  wire [15:0]           i_angle_step,
    input  wire [15:0]           i_start_angle,
    output lidtf_pkg::t_job      o_job
);
    import lidtf_pkg::*;

    function automatic logic [ANGLE_BITS-1:0] scale_angle(input logic [15:0] v);
        logic [39:0] wide;
        wide = {v, 24'd0};
        return wide[39 -: ANGLE_BITS];
    endfunction

    localparam logic [39:0] BEAM_RST_WIDE = {START_ANGLE_RST, 24'd0};
    localparam logic [ANGLE_BITS-1:0] BEAM_RST = BEAM_RST_WIDE[39 -: ANGLE_BITS];

    logic [ANGLE_BITS-1:0]    r_beam_angle;
    logic [ANGLE_BITS-1:0]    n_beam_angle;
    logic [ANGLE_BITS-1:0]    angle_used;
    logic [ANGLE_BITS+31:0]   angle_wide;
    logic [31:0]              angle_turn;
    logic [31:0]              angle_folded;

    always_comb begin
        angle_used   = i_item.scan_start ? scale_angle(i_start_angle) : r_beam_angle;
        n_beam_angle = angle_used + scale_angle(i_angle_step);
        angle_wide   = {angle_used, 32'd0};
        angle_turn   = angle_wide[ANGLE_BITS+31:ANGLE_BITS];
        // The second and third quadrants mirror onto the first and fourth.
        if (angle_turn[31:30] == 2'b01 || angle_turn[31:30] == 2'b10) begin
            angle_folded = 32'h8000_0000 - angle_turn;
        end else begin
            angle_folded = angle_turn;
        end
    end

    assign o_job.range_mm = i_item.range_mm;
    assign o_job.angle    = angle_folded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_angle <= BEAM_RST;
        end else if (i_accept) begin
            r_beam_angle <= n_beam_angle;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lidtf_queue.sv =====
`default_nettype none

module lidtf_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  lidtf_pkg::t_job  i_data,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_valid,
    output lidtf_pkg::t_job  o_data
);
    import lidtf_pkg::*;

    t_job                   r_entry [QUEUE_DEPTH];
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;
    logic [QUEUE_CNT_W-1:0] wr_pos;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[0];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign wr_pos  = r_count - QUEUE_CNT_W'(do_pop);

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            if (do_push && wr_pos == QUEUE_CNT_W'(k)) begin
                r_entry[k] <= i_data;
            end else if (do_pop) begin
                r_entry[k] <= r_entry[k+1];
            end
        end
        if (do_push && wr_pos == QUEUE_CNT_W'(QUEUE_DEPTH - 1)) begin
            r_entry[QUEUE_DEPTH-1] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !(i_pop && o_valid)) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on a lone push");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lidtf_back.sv =====
`default_nettype none

module lidtf_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_job_valid,
    input  lidtf_pkg::t_job       i_job,
    output logic                  o_job_pop,
    input  lidtf_pkg::t_back_cfg  i_cfg,
    input  wire                   i_pop,
    output logic                  o_out_valid,
    output lidtf_pkg::t_out_item  o_out_item
);
    import lidtf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SCALE,
        ST_TILT,
        ST_DONE
    } t_state;

    t_state               r_state;
    logic [3:0]           r_iter;
    logic signed [33:0]   r_x;
    logic signed [33:0]   r_y;
    logic signed [32:0]   r_z;
    logic [15:0]          r_range;
    logic signed [32:0]   r_p1;
    logic signed [48:0]   r_p2;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic signed [33:0]   dx;
    logic signed [33:0]   dy;
    logic signed [32:0]   dz;
    logic signed [33:0]   y_round;
    logic signed [33:0]   sine_wide;
    logic signed [15:0]   sine_q15;
    logic signed [48:0]   limit;
    logic                 keep;
    logic                 out_free;

    always_comb begin
        dx      = r_y >>> r_iter;
        dy      = r_x >>> r_iter;
        dz      = $signed({1'b0, atan_turn(r_iter)});
        y_round = r_y + 34'sd16384;
        sine_wide = y_round >>> 15;
        if (sine_wide > 34'sd32767) begin
            sine_q15 = 16'sh7FFF;
        end else if (sine_wide < -34'sd32768) begin
            sine_q15 = 16'sh8000;
        end else begin
            sine_q15 = sine_wide[15:0];
        end
        limit = {{3{i_cfg.height_floor[15]}}, i_cfg.height_floor, 30'd0};
        keep  = (r_range < i_cfg.min_range) || (r_p2 > limit);
    end

    assign out_free    = !r_out_valid || i_pop;
    assign o_job_pop   = (r_state == ST_IDLE) && i_job_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_x     <= CORDIC_X0;
                        r_y     <= '0;
                        r_z     <= $signed({i_job.angle[31], i_job.angle});
                        r_range <= i_job.range_mm;
                        r_iter  <= '0;
                        r_state <= ST_ROTATE;
                    end
                end
                ST_ROTATE: begin
                    if (!r_z[32]) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - dz;
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + dz;
                    end
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == CORDIC_LAST) begin
                        r_state <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    r_p1    <= $signed({1'b0, r_range}) * sine_q15;
                    r_state <= ST_TILT;
                end
                ST_TILT: begin
                    r_p2    <= r_p1 * i_cfg.tilt_sine;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_item.range_out <= r_range;
                        r_out_item.keep      <= keep;
                        r_out_valid          <= 1'b1;
                        r_state              <= ST_IDLE;
                    end else if (i_pop) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished transaction was not delivered");

    a_rotate_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROTATE && r_iter == CORDIC_LAST) |=> (r_state == ST_SCALE))
        else $error("rotation did not end after the last iteration");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lidar_tilt_ground_filter.sv =====
// The back end works on one transaction at a time, through the 16-iteration
// CORDIC rotator and the two multiply stages that share it; it takes no new
// transaction until the last one has passed to the output register.
// A two-entry queue lets the input side accept while the back end is busy.
// Reset is synchronous and active low; it clears all queues and control state,
// loads the register reset values and sets the beam angle to the start angle.
`default_nettype none

module lidar_tilt_ground_filter #(
    parameter int ANGLE_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   push,
    output logic                  full,
    input  lidtf_pkg::t_in_item   i_in_item,
    output logic                  empty,
    input  wire                   pop,
    output lidtf_pkg::t_out_item  o_out_item,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire [4:0]             paddr,
    input  wire [31:0]            pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import lidtf_pkg::*;

    logic [15:0] r_angle_step;
    logic [15:0] r_start_angle;
    logic [15:0] r_min_range;
    logic [15:0] r_tilt_sine;
    logic [15:0] r_height_floor;

    logic        cfg_write;
    logic [2:0]  reg_idx;
    logic        in_accept;
    logic        queue_full;
    logic        queue_valid;
    logic        queue_pop;
    logic        out_valid;
    t_job        front_job;
    t_job        queue_job;
    t_back_cfg   back_cfg;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_step   <= ANGLE_STEP_RST;
            r_start_angle  <= START_ANGLE_RST;
            r_min_range    <= MIN_RANGE_RST;
            r_tilt_sine    <= TILT_SINE_RST;
            r_height_floor <= HEIGHT_FLOOR_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_ANGLE_STEP:   r_angle_step   <= pwdata[15:0];
                REG_START_ANGLE:  r_start_angle  <= pwdata[15:0];
                REG_MIN_RANGE:    r_min_range    <= pwdata[15:0];
                REG_TILT_SINE:    r_tilt_sine    <= pwdata[15:0];
                REG_HEIGHT_FLOOR: r_height_floor <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ANGLE_STEP:   prdata = {16'd0, r_angle_step};
            REG_START_ANGLE:  prdata = {16'd0, r_start_angle};
            REG_MIN_RANGE:    prdata = {16'd0, r_min_range};
            REG_TILT_SINE:    prdata = {16'd0, r_tilt_sine};
            REG_HEIGHT_FLOOR: prdata = {16'd0, r_height_floor};
            default:          prdata = 32'd0;
        endcase
    end

    assign full      = queue_full;
    assign in_accept = push && !queue_full;
    assign empty     = !out_valid;

    assign back_cfg.min_range    = r_min_range;
    assign back_cfg.tilt_sine    = r_tilt_sine;
    assign back_cfg.height_floor = r_height_floor;

    lidtf_front #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_item        (i_in_item),
        .i_angle_step  (r_angle_step),
        .i_start_angle (r_start_angle),
        .o_job         (front_job)
    );

    lidtf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_job),
        .i_pop   (queue_pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_data  (queue_job)
    );

    lidtf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_pop   (queue_pop),
        .i_cfg       (back_cfg),
        .i_pop       (pop && out_valid),
        .o_out_valid (out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== sim/lidar_tilt_ground_filter_tb.sv =====
`default_nettype none

module lidar_tilt_ground_filter_tb;

    import lidtf_pkg::*;

    localparam int ANGLE_BITS = 16;
    localparam int LATENCY    = 21;

    class ground_filter_check;
        logic        [15:0] angle_step;
        logic signed [15:0] start_angle;
        logic        [15:0] min_range;
        logic signed [15:0] tilt_sine;
        logic signed [15:0] height_floor;
        longint unsigned    beam_angle;
        t_out_item          awaited[$];
        int unsigned        n_fail;
        longint             atan_turn_tab[16] = '{
            536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10680862, 5340245,
            2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861
        };

        function new();
            angle_step   = ANGLE_STEP_RST;
            start_angle  = START_ANGLE_RST;
            min_range    = MIN_RANGE_RST;
            tilt_sine    = TILT_SINE_RST;
            height_floor = HEIGHT_FLOOR_RST;
            beam_angle   = to_angle(START_ANGLE_RST);
            n_fail       = 0;
        endfunction

        // Register angles are in 1/65536 turn; rescale them to ANGLE_BITS.
        function longint unsigned to_angle(logic [15:0] v);
            longint unsigned a;
            a = v;
            a = (a << 8) >> (24 - ANGLE_BITS);
            return a & ((64'd1 << ANGLE_BITS) - 1);
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                REG_ANGLE_STEP:   angle_step   = v;
                REG_START_ANGLE:  start_angle  = v;
                REG_MIN_RANGE:    min_range    = v;
                REG_TILT_SINE:    tilt_sine    = v;
                REG_HEIGHT_FLOOR: height_floor = v;
                default: ;
            endcase
        endfunction

        function longint beam_sine(longint unsigned ang);
            bit [31:0] a;
            longint    x, y, z, dx, dy, s;
            a = 32'(ang << (32 - ANGLE_BITS));
            if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
                a = 32'h8000_0000 - a;
            end
            z = longint'($signed(a));
            x = 652032874;
            y = 0;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= atan_turn_tab[i];
                end else begin
                    x += dx;
                    y -= dy;
                    z += atan_turn_tab[i];
                end
            end
            s = (y + 16384) >>> 15;
            if (s > 32767) begin
                s = 32767;
            end
            if (s < -32768) begin
                s = -32768;
            end
            return s;
        endfunction

        function void classify_sample(t_in_item it);
            t_out_item want;
            longint    height, limit;
            if (it.scan_start) begin
                beam_angle = to_angle(start_angle);
            end
            height = longint'(it.range_mm) * beam_sine(beam_angle) * longint'(tilt_sine);
            limit  = longint'(height_floor) * 1073741824;
            want.range_out = it.range_mm;
            want.keep      = (it.range_mm < min_range) || (height > limit);
            beam_angle = (beam_angle + to_angle(angle_step)) & ((64'd1 << ANGLE_BITS) - 1);
            awaited.push_back(want);
        endfunction

        function void check_return(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                $error("unexpected transaction: range_out %0d keep %0d",
                       got.range_out, got.keep);
                n_fail++;
                return;
            end
            want = awaited.pop_front();
            if (got.range_out !== want.range_out) begin
                $error("range_out: expected %0d, actual %0d", want.range_out, got.range_out);
                n_fail++;
            end
            if (got.keep !== want.keep) begin
                $error("keep: expected %0d, actual %0d", want.keep, got.keep);
                n_fail++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_in_item;
    logic        empty;
    logic        pop;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ground_filter_check sb;
    int push_idle_max;
    int pop_idle_max;

    lidar_tilt_ground_filter #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    task feed(input logic [15:0] range_mm, input logic scan_start);
        int       gap;
        t_in_item it;
        gap = $urandom_range(0, push_idle_max);
        it.range_mm   = range_mm;
        it.scan_start = scan_start;
        for (int k = 0; k < gap; k++) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push      = 1'b1;
        i_in_item = it;
        do @(posedge i_clk); while (full !== 1'b0);
        sb.classify_sample(it);
    endtask

    task drain_returns();
        int gap;
        forever begin
            gap = $urandom_range(0, pop_idle_max);
            for (int k = 0; k < gap; k++) begin
                @(negedge i_clk);
                pop = 1'b0;
            end
            @(negedge i_clk);
            pop = 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            sb.check_return(o_out_item);
        end
    endtask

    task wait_idle();
        @(negedge i_clk);
        push = 1'b0;
        while (sb.awaited.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    task write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'd0, val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task configure(input logic [15:0] step, input logic [15:0] start,
                   input logic [15:0] min_rng, input logic [15:0] tilt,
                   input logic [15:0] floor_mm);
        write_reg(REG_ANGLE_STEP, step);
        write_reg(REG_START_ANGLE, start);
        write_reg(REG_MIN_RANGE, min_rng);
        write_reg(REG_TILT_SINE, tilt);
        write_reg(REG_HEIGHT_FLOOR, floor_mm);
    endtask

    function logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int          n;
        int          len;
        bit          first;
        logic        start;
        logic [15:0] r;
        push          = 1'b0;
        pop           = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_item     = '0;
        i_rst_n       = 1'b0;
        push_idle_max = 16;
        pop_idle_max  = 16;
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        fork
            drain_returns();
        join_none

        // Samples before any scan start use the reset start angle.
        feed(16'd0, 1'b0);
        feed(16'hFFFF, 1'b0);
        feed(16'd1234, 1'b0);

        // Quarter-turn steps from straight up; a height equal to the floor is dropped.
        wait_idle();
        configure(16'd16384, 16'd16384, 16'd100, 16'h7FFF, 16'd0);
        feed(16'd500, 1'b1);
        feed(16'd500, 1'b0);
        feed(16'd500, 1'b0);
        feed(16'd50, 1'b0);
        feed(16'd100, 1'b0);
        feed(16'hFFFF, 1'b1);
        feed(16'd99, 1'b0);

        wait_idle();
        configure(16'hFFFF, 16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF);
        feed(16'hFFFE, 1'b1);
        feed(16'hFFFF, 1'b0);
        feed(16'd0, 1'b0);
        feed(16'd7, 1'b0);

        wait_idle();
        configure(16'd0, 16'h7FFF, 16'd0, 16'h7FFF, 16'h8000);
        feed(16'hFFFF, 1'b1);
        feed(16'd0, 1'b0);
        feed(16'd1, 1'b1);
        feed(16'd2, 1'b0);

        // A new start angle must wait for the next scan start.
        wait_idle();
        write_reg(REG_START_ANGLE, 16'h4000);
        feed(16'd300, 1'b0);
        feed(16'd300, 1'b1);

        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            configure(pick16(), pick16(),
                      ($urandom_range(0, 1) == 0) ? pick16() : 16'($urandom_range(0, 3000)),
                      pick16(), pick16());
            push_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            pop_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 16;
            n     = 0;
            first = 1'b1;
            while (n < 53) begin
                len = $urandom_range(1, 40);
                for (int k = 0; k < len && n < 53; k++) begin
                    if (k == 0) begin
                        start = first ? ($urandom_range(0, 3) != 0) : 1'b1;
                    end else begin
                        start = 1'b0;
                    end
                    if ($urandom_range(0, 15) == 0) begin
                        start = ~start;
                    end
                    if ($urandom_range(0, 7) == 0) begin
                        r = sb.min_range - 16'd1 + 16'($urandom_range(0, 2));
                    end else begin
                        r = 16'($urandom);
                    end
                    feed(r, start);
                    n++;
                end
                first = 1'b0;
            end
        end

        wait_idle();
        if (sb.n_fail == 0) begin
            $display("** lidar_tilt_ground_filter: PASSED **");
        end else begin
            $display("** lidar_tilt_ground_filter: FAILED **");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("** lidar_tilt_ground_filter: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/lidtf_pkg.sv
rtl/core/lidtf_front.sv
rtl/core/lidtf_queue.sv
rtl/core/lidtf_back.sv
rtl/core/lidar_tilt_ground_filter.sv
sim/lidar_tilt_ground_filter_tb.sv
